FILE: sv/sdl_pkg.sv
// Shared types and constants for the signed decimal display digit writer.
`default_nettype none

package sdl_pkg;

   // Input value and result field widths.
   localparam int ValueWidth   = 16;
   localparam int MagWidth     = 14;
   localparam int AddressWidth = 3;
   localparam int CodeWidth    = 4;

   // Saturation limits of the shown value.
   localparam int ValueMax = 9999;
   localparam int ValueMin = -999;

   // Data codes sent to the display driver.
   localparam logic [CodeWidth-1:0] ClearCode = 4'd0;
   localparam logic [CodeWidth-1:0] MinusCode = 4'd10;

   // Number of register writes produced by one value.
   localparam int WritesPerRun = 8;

   // Digit extraction steps: thousands, hundreds, tens.
   typedef enum logic [1:0] {
      StepThousands = 2'd0,
      StepHundreds  = 2'd1,
      StepTens      = 2'd2
   } step_type;

   // One digit peeled off the running remainder.
   typedef struct packed {
      logic [CodeWidth-1:0] digit;
      logic [MagWidth-1:0]  remainder;
   } digit_step_type;

endpackage : sdl_pkg

`default_nettype wire

FILE: sv/sdl_digit_step.sv
// One decimal digit step: compares against constant multiples of the place value.
`default_nettype none

module sdl_digit_step (
   input  sdl_pkg::step_type       step_sel,
   input  logic [13:0]             remainder,
   output sdl_pkg::digit_step_type result
);

   localparam int MagW  = sdl_pkg::MagWidth;
   localparam int CodeW = sdl_pkg::CodeWidth;

   // Multiples 0..9 of the place value for each step.
   localparam logic [MagW-1:0] Thr1000 [10] = '{
      14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
      14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000};
   localparam logic [MagW-1:0] Thr100 [10] = '{
      14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
      14'd500, 14'd600, 14'd700, 14'd800, 14'd900};
   localparam logic [MagW-1:0] Thr10 [10] = '{
      14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
      14'd50, 14'd60, 14'd70, 14'd80, 14'd90};

   logic [MagW-1:0] thr [10];
   logic [CodeW-1:0] digit;

   // Pick the threshold row for the current place value.
   always_comb begin
      case (step_sel)
         sdl_pkg::StepThousands: thr = Thr1000;
         sdl_pkg::StepHundreds:  thr = Thr100;
         sdl_pkg::StepTens:      thr = Thr10;
         default:                thr = Thr10;
      endcase
   end

   // The digit is the largest multiple that still fits; the compares are independent.
   always_comb begin
      digit = '0;
      for (int k = 1; k < 10; k++) begin
         if (remainder >= thr[k]) begin
            digit = CodeW'(k);
         end
      end
   end

   assign result.digit     = digit;
   assign result.remainder = remainder - thr[digit];

endmodule : sdl_digit_step

`default_nettype wire

FILE: sv/signed_decimal_led_digit_writer.sv
// Top level: turns a signed value into eight display-driver digit register writes.
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+---------------------------
//   request  | req_value                                     | start high, busy low
//   response | rsp_digit_address, rsp_digit_code,            | rsp_strobe, one cycle each
//            | rsp_last_of_run                               |
//
// Each value gives four clears and then four digits, one register write leaving per cycle.
// A new value is taken at the edge that launches the last write, so values follow each
// other with no gap. The first write reaches the ports through the active flag and the
// strobe register. The digits are peeled off one per cycle by a compare unit while the
// clears go out. Synchronous reset clears the sequencer and the strobe.
// Writes cannot be held off by the receiver.
`default_nettype none

module signed_decimal_led_digit_writer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_value,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_digit_address,
   output logic [3:0]         rsp_digit_code,
   output logic               rsp_last_of_run
);

   localparam int MagW   = sdl_pkg::MagWidth;
   localparam int CodeW  = sdl_pkg::CodeWidth;
   localparam int AddrW  = sdl_pkg::AddressWidth;
   localparam int CountW = $clog2(sdl_pkg::WritesPerRun);
   localparam logic [CountW-1:0] LastCount  = CountW'(sdl_pkg::WritesPerRun - 1);
   localparam logic [CountW-1:0] FirstDigit = CountW'(sdl_pkg::WritesPerRun / 2);
   localparam logic signed [15:0] SatHigh = 16'(sdl_pkg::ValueMax);
   localparam logic signed [15:0] SatLow  = 16'(sdl_pkg::ValueMin);

   logic              active_ff, active_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              neg_ff;
   logic [MagW-1:0]   rem_ff;
   logic [CodeW-1:0]  digit_ff [3];
   logic              strobe_ff;
   logic              last_ff;
   logic [AddrW-1:0]  address_ff, address_in;
   logic [CodeW-1:0]  code_ff, code_in;

   logic              accept;
   logic              sat_neg;
   logic [MagW-1:0]   sat_mag;
   logic              step_en;
   sdl_pkg::step_type       step_sel;
   sdl_pkg::digit_step_type step_result;

   // Accept during idle or during the final write of the current run.
   assign busy   = active_ff && (count_ff != LastCount);
   assign accept = start && !busy;

   // Saturate to the display range and split into sign and magnitude.
   always_comb begin
      if (req_value > SatHigh) begin
         sat_neg = 1'b0;
         sat_mag = MagW'(sdl_pkg::ValueMax);
      end else if (req_value < SatLow) begin
         sat_neg = 1'b1;
         sat_mag = MagW'(-sdl_pkg::ValueMin);
      end else if (req_value[15]) begin
         sat_neg = 1'b1;
         sat_mag = MagW'(-req_value);
      end else begin
         sat_neg = 1'b0;
         sat_mag = MagW'(req_value);
      end
   end

   // Digit extraction runs on counts 0 to 2 of a run: thousands, hundreds, tens.
   assign step_en  = active_ff && (count_ff < CountW'(3));
   assign step_sel = sdl_pkg::step_type'(count_ff[1:0]);

   sdl_digit_step u_digit_step (
      .step_sel  (step_sel),
      .remainder (rem_ff),
      .result    (step_result)
   );

   // Sequencer next state.
   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      if (accept) begin
         active_in = 1'b1;
         count_in  = '0;
      end else if (active_ff) begin
         active_in = (count_ff != LastCount);
         count_in  = count_ff + 1'b1;
      end
   end

   // Address and code of the write leaving this cycle.
   always_comb begin
      if (count_ff < FirstDigit) begin
         address_in = AddrW'({1'b0, count_ff[1:0]}) + 1'b1;
      end else begin
         address_in = AddrW'(4) - AddrW'({1'b0, count_ff[1:0]});
      end
      case (count_ff)
         3'd4:    code_in = neg_ff ? sdl_pkg::MinusCode : digit_ff[0];
         3'd5:    code_in = digit_ff[1];
         3'd6:    code_in = digit_ff[2];
         3'd7:    code_in = rem_ff[CodeW-1:0];
         default: code_in = sdl_pkg::ClearCode;
      endcase
   end

   // Control state and the response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         strobe_ff <= active_ff;
         last_ff   <= active_ff && (count_ff == LastCount);
      end
   end

   // Value, digit and response payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff <= sat_neg;
         rem_ff <= sat_mag;
      end else if (step_en) begin
         rem_ff               <= step_result.remainder;
         digit_ff[count_ff[1:0]] <= step_result.digit;
      end
      address_ff <= address_in;
      code_ff    <= code_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_digit_address = address_ff;
   assign rsp_digit_code    = code_ff;
   assign rsp_last_of_run   = last_ff;

endmodule : signed_decimal_led_digit_writer

`default_nettype wire

FILE: sv/sdl_port_checker.sv
// Port-level assertions for the digit writer, bound to the top level.
`default_nettype none

module sdl_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [2:0]         rsp_digit_address,
   input logic [3:0]         rsp_digit_code,
   input logic               rsp_last_of_run
);

   // An accepted value starts its write run, with the strobe registered from the active flag.
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_strobe)
      else $error("accepted value did not start a write run");

   // The closing beat is a strobed write to the rightmost digit.
   a_last_is_units: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_run |-> rsp_strobe && rsp_digit_address == 3'd1)
      else $error("last beat not on digit address 1");

   // The minus sign only ever goes to the leftmost digit.
   a_minus_leftmost: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_digit_code == sdl_pkg::MinusCode |-> rsp_digit_address == 3'd4)
      else $error("minus sign written to a digit other than the leftmost");

   // Busy only rises after a value was taken.
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start");

   // A strobed beat always carries a valid address and code.
   a_beat_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_digit_address != 3'd0 && rsp_digit_address <= 3'd4
                     && rsp_digit_code <= sdl_pkg::MinusCode)
      else $error("beat address or code out of range");

endmodule : sdl_port_checker

bind signed_decimal_led_digit_writer sdl_port_checker u_sdl_port_checker (.*);

`default_nettype wire
